>>> rtl/core/chol_pkg.sv
// ----------------------------------------------------------------------------
// chol_pkg: shared types and constants of the Cholesky factor-and-solve block
// Widths, request codes, register indexes and the controller command struct.
// ----------------------------------------------------------------------------
package chol_pkg;

  localparam int unsigned MaxSize = 16;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned AddrW   = 8;
  localparam int unsigned AccW    = 72;

  localparam logic [1:0] ReqLoadMat = 2'd0;
  localparam logic [1:0] ReqLoadVec = 2'd1;
  localparam logic [1:0] ReqRun     = 2'd2;

  localparam logic [1:0] CfgSize  = 2'd0;
  localparam logic [1:0] CfgFloor = 2'd1;

  // accumulator start source
  localparam logic [1:0] InitMat = 2'd0;
  localparam logic [1:0] InitVec = 2'd1;
  localparam logic [1:0] InitY   = 2'd2;

  // multiplier second operand source
  localparam logic [1:0] OpMat = 2'd0;
  localparam logic [1:0] OpY   = 2'd1;
  localparam logic [1:0] OpX   = 2'd2;

  // destination of a divide result
  localparam logic [1:0] DstMat = 2'd0;
  localparam logic [1:0] DstY   = 2'd1;
  localparam logic [1:0] DstX   = 2'd2;

  typedef struct packed {
    logic             mem_rd;
    logic [AddrW-1:0] mem_addr;
    logic             acc_init;
    logic [1:0]       init_src;
    logic             mul_a_cap;
    logic             mac_go;
    logic [1:0]       op_src;
    logic [IdxW-1:0]  op_idx;
    logic             sqrt_go;
    logic             div_go;
    logic [1:0]       div_dst;
    logic [IdxW-1:0]  dst_idx;
    logic [AddrW-1:0] dst_addr;
    logic             diag_cap;
  } chol_cmd_t;

  typedef struct packed {
    logic mac_busy;
    logic unit_busy;
    logic pivot_bad;
  } chol_sts_t;

endpackage

>>> rtl/core/chol_if.sv
// ----------------------------------------------------------------------------
// chol_req_if / chol_res_if: valid-ready channels of the block
// Request and result channels with source and sink modports.
// ----------------------------------------------------------------------------
interface chol_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  row;
  logic [3:0]  col;
  logic [31:0] value;
  modport source (output valid, req_type, row, col, value, input ready);
  modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

interface chol_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] solution_value;
  logic [3:0]  index;
  logic        status;
  logic        last;
  modport source (output valid, solution_value, index, status, last, input ready);
  modport sink   (input valid, solution_value, index, status, last, output ready);
endinterface

>>> rtl/core/cholesky_factor_and_solve.sv
// Load requests: one request per cycle while the block is idle.
// Run: each step accumulates its product terms, then divides or takes a square
// root; results then stream at one per cycle while the result side is ready.
// Throughput is set by the single shared MAC pipe and the bit-serial divider.
// Reset clears control and registers (size 16, floor 0); stores stay undefined.
// ----------------------------------------------------------------------------
// cholesky_factor_and_solve: top level
// Request decode, configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
module cholesky_factor_and_solve import chol_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  chol_req_if.sink    req,
  chol_res_if.source  res,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i
);

  logic [4:0]  size_q;
  logic [30:0] floor_q;
  logic [4:0]  n_eff;
  logic        busy, ovalid, ofail, olast;
  logic [IdxW-1:0] oidx;
  chol_cmd_t   cmd;
  chol_sts_t   sts;
  logic [31:0] xv [MaxSize];
  logic        acc;

  // hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= 5'd16;
      floor_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgSize)  size_q  <= cfg_data_i[4:0];
      if (cfg_idx_i == CfgFloor) floor_q <= cfg_data_i;
    end
  end

  assign n_eff = (size_q == 5'd0) ? 5'd1 : (size_q > 5'd16) ? 5'd16 : size_q;
  assign req.ready = !busy;
  assign acc = req.valid && req.ready;

  chol_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i    (acc && req.req_type == ReqRun),
    .n_i        (n_eff),
    .sts_i      (sts),
    .out_ready_i(res.ready),
    .cmd_o      (cmd),
    .busy_o     (busy),
    .out_valid_o(ovalid),
    .out_fail_o (ofail),
    .out_idx_o  (oidx),
    .out_last_o (olast)
  );

  chol_dp u_dp (
    .clk_i, .rst_ni,
    .ld_mat_i (acc && req.req_type == ReqLoadMat),
    .ld_vec_i (acc && req.req_type == ReqLoadVec),
    .ld_addr_i({req.row, req.col}),
    .ld_val_i (req.value),
    .floor_i  (floor_q),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .x_o      (xv)
  );

  always_comb begin
    res.solution_value = ofail ? 32'd0 : xv[oidx];
  end
  assign res.valid  = ovalid;
  assign res.index  = oidx;
  assign res.status = ofail;
  assign res.last   = olast;

endmodule

>>> rtl/core/chol_div.sv
// ----------------------------------------------------------------------------
// chol_div: restoring divider and integer square root
// Quotient (t*2^16)/d rounded half away from zero and saturated, one bit a
// cycle; floor(sqrt(s*2^16)) two radicand bits a cycle.
// ----------------------------------------------------------------------------
module chol_div import chol_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        div_go_i,
  input  logic        sqrt_go_i,
  input  logic [31:0] num_i,   // signed saturated numerator
  input  logic [31:0] den_i,   // positive divisor
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] res_o
);

  logic        busy_q, busy_d, mode_q, mode_d, neg_q, neg_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [48:0] rem_q, rem_d;
  logic [48:0] dvd_q, dvd_d;
  logic [48:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic [31:0] res_q, res_d;
  logic [48:0] trial;
  logic [50:0] rr;
  logic [50:0] tt;
  logic [49:0] qr;
  logic [31:0] mag;

  assign mag = num_i[31] ? (32'd0 - num_i) : num_i;

  always_comb begin
    busy_d = busy_q; mode_d = mode_q; neg_d = neg_q; cnt_d = cnt_q;
    rem_d = rem_q; dvd_d = dvd_q; quo_d = quo_q; den_d = den_q;
    res_d = res_q; done_d = 1'b0;
    trial = '0; rr = '0; tt = '0; qr = '0;
    if (div_go_i) begin
      busy_d = 1'b1; mode_d = 1'b0; neg_d = num_i[31];
      dvd_d = {1'b0, mag, 16'd0}; rem_d = '0; quo_d = '0;
      den_d = den_i; cnt_d = 6'd49;
    end else if (sqrt_go_i) begin
      busy_d = 1'b1; mode_d = 1'b1; neg_d = 1'b0;
      dvd_d = {1'b0, num_i, 16'd0}; rem_d = '0; quo_d = '0; cnt_d = 6'd24;
    end else if (busy_q) begin
      if (!mode_q) begin
        // shift in one dividend bit, subtract when it fits
        trial = {rem_q[47:0], dvd_q[48]};
        dvd_d = {dvd_q[47:0], 1'b0};
        if (trial >= {17'd0, den_q}) begin
          rem_d = trial - {17'd0, den_q};
          quo_d = {quo_q[47:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[47:0], 1'b0};
        end
      end else begin
        // bring down two radicand bits, one root bit
        rr = {rem_q, dvd_q[47:46]};
        tt = {quo_q[48:0], 2'b01};
        dvd_d = {dvd_q[46:0], 2'b00};
        if (rr >= tt) begin
          rem_d = 49'(rr - tt);
          quo_d = {quo_q[47:0], 1'b1};
        end else begin
          rem_d = 49'(rr);
          quo_d = {quo_q[47:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (mode_q) begin
          res_d = quo_d[31:0];
        end else begin
          // round half away: remainder*2 >= divisor
          qr = {1'b0, quo_d} + (({rem_d, 1'b0} >= {18'd0, den_q}) ? 50'd1 : 50'd0);
          if (den_q == 32'd0) res_d = '0;
          else if (neg_q) res_d = (qr > 50'h80000000) ? 32'h80000000 : 32'(50'd0 - qr);
          else res_d = (qr > 50'h7fffffff) ? 32'h7fffffff : qr[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; neg_q <= neg_d; rem_q <= rem_d; dvd_q <= dvd_d;
    quo_q <= quo_d; den_q <= den_d; res_q <= res_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/core/chol_dp.sv
// ----------------------------------------------------------------------------
// chol_dp: datapath of the Cholesky block
// Matrix memory, vector registers, multiply-accumulate pipe and the
// divide/square-root unit, steered by the controller's commands.
// ----------------------------------------------------------------------------
module chol_dp import chol_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ld_mat_i,
  input  logic             ld_vec_i,
  input  logic [AddrW-1:0] ld_addr_i,
  input  logic [31:0]      ld_val_i,
  input  logic [30:0]      floor_i,
  input  chol_cmd_t        cmd_i,
  output chol_sts_t        sts_o,
  output logic [31:0]      x_o [MaxSize]
);

  logic [31:0] mem_q [MaxSize*MaxSize];
  logic [31:0] vec_q [MaxSize];
  logic [31:0] y_q   [MaxSize];
  logic [31:0] x_q   [MaxSize];
  logic [31:0] rd_q;
  logic [31:0] a_q, b_q, diag_q;
  logic [63:0] p_q;
  logic        v1_q, v2_q, v3_q, go_q;
  logic signed [AccW-1:0] acc_q;
  logic [1:0]  dst_q;
  logic [IdxW-1:0]  didx_q;
  logic [AddrW-1:0] daddr_q;
  logic        sq_q;
  logic [31:0] sat;
  logic [63:0] pm;
  logic [48:0] pr;
  logic signed [AccW-1:0] prs;
  logic        dv_busy, dv_done;
  logic [31:0] dv_res;
  logic [1:0]  opsrc_q;
  logic [IdxW-1:0] opidx_q;
  logic [1:0]  isrc_q;

  // saturate accumulator
  always_comb begin
    if (acc_q > AccW'(signed'(32'sh7fffffff)))       sat = 32'h7fffffff;
    else if (acc_q < AccW'(signed'(-33'sh80000000))) sat = 32'h80000000;
    else sat = acc_q[31:0];
  end

  assign pm  = p_q[63] ? (64'd0 - p_q) : p_q;
  assign pr  = 49'((pm + 64'h8000) >> 16);
  assign prs = p_q[63] ? -AccW'(signed'({1'b0, pr})) : AccW'(signed'({1'b0, pr}));

  // memory: load port, write-back, registered read
  always_ff @(posedge clk_i) begin
    if (ld_mat_i) mem_q[ld_addr_i] <= ld_val_i;
    else if (dv_done && !sq_q && dst_q == DstMat) mem_q[daddr_q] <= dv_res;
    else if (dv_done && sq_q) mem_q[daddr_q] <= dv_res;
    rd_q <= mem_q[cmd_i.mem_addr];
    if (ld_vec_i) vec_q[ld_addr_i[AddrW-1:IdxW]] <= ld_val_i;
    if (dv_done && !sq_q && dst_q == DstY) y_q[didx_q] <= dv_res;
    if (dv_done && !sq_q && dst_q == DstX) x_q[didx_q] <= dv_res;
    if (dv_done && sq_q) diag_q <= dv_res;
    else if (cmd_i.diag_cap) diag_q <= rd_q;
    if (cmd_i.mul_a_cap) a_q <= rd_q;
  end

  // multiply-accumulate pipe: operand, product, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; go_q <= 1'b0;
    end else begin
      go_q <= cmd_i.acc_init;
      v1_q <= cmd_i.mac_go;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    opsrc_q <= cmd_i.op_src;
    opidx_q <= cmd_i.op_idx;
    isrc_q  <= cmd_i.init_src;
    // stage after read: pick B
    case (opsrc_q)
      OpY:     b_q <= y_q[opidx_q];
      OpX:     b_q <= x_q[opidx_q];
      default: b_q <= rd_q;
    endcase
    p_q <= 64'(signed'(a_q)) * 64'(signed'(b_q));
    if (cmd_i.acc_init && cmd_i.init_src == InitY) begin
      acc_q <= AccW'(signed'(y_q[cmd_i.op_idx]));
    end else if (cmd_i.acc_init && cmd_i.init_src == InitVec) begin
      acc_q <= AccW'(signed'(vec_q[cmd_i.op_idx]));
    end else if (go_q && isrc_q == InitMat) begin
      acc_q <= AccW'(signed'(rd_q));
    end else if (v3_q) begin
      acc_q <= acc_q - prs;
    end
    if (cmd_i.div_go || cmd_i.sqrt_go) begin
      dst_q <= cmd_i.div_dst; didx_q <= cmd_i.dst_idx;
      daddr_q <= cmd_i.dst_addr; sq_q <= cmd_i.sqrt_go;
    end
  end

  chol_div u_div (
    .clk_i, .rst_ni,
    .div_go_i (cmd_i.div_go),
    .sqrt_go_i(cmd_i.sqrt_go),
    .num_i    (sat),
    .den_i    (diag_q),
    .busy_o   (dv_busy),
    .done_o   (dv_done),
    .res_o    (dv_res)
  );

  assign sts_o.mac_busy  = v1_q | v2_q | v3_q;
  assign sts_o.unit_busy = dv_busy | dv_done;
  assign sts_o.pivot_bad = acc_q <= AccW'(signed'({1'b0, floor_i}));
  assign x_o = x_q;

endmodule

>>> rtl/core/chol_ctrl.sv
// ----------------------------------------------------------------------------
// chol_ctrl: sequencer of the Cholesky block
// Walks the factor, forward and backward loops and drives the datapath.
// ----------------------------------------------------------------------------
module chol_ctrl import chol_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [4:0]      n_i,
  input  chol_sts_t       sts_i,
  input  logic            out_ready_i,
  output chol_cmd_t       cmd_o,
  output logic            busy_o,
  output logic            out_valid_o,
  output logic            out_fail_o,
  output logic [IdxW-1:0] out_idx_o,
  output logic            out_last_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StInit  = 4'd1;
  localparam logic [3:0] StIw    = 4'd2;
  localparam logic [3:0] StRdA   = 4'd3;
  localparam logic [3:0] StRdB   = 4'd4;
  localparam logic [3:0] StMw    = 4'd5;
  localparam logic [3:0] StOp    = 4'd6;
  localparam logic [3:0] StDiag  = 4'd7;
  localparam logic [3:0] StUw    = 4'd8;
  localparam logic [3:0] StEmit  = 4'd9;
  localparam logic [3:0] StFail  = 4'd10;
  localparam logic [3:0] StDw    = 4'd11;

  // phases
  localparam logic [1:0] PhPiv = 2'd0;
  localparam logic [1:0] PhOff = 2'd1;
  localparam logic [1:0] PhFwd = 2'd2;
  localparam logic [1:0] PhBwd = 2'd3;

  logic [3:0] st_q, st_d;
  logic [1:0] ph_q, ph_d;
  logic [IdxW:0] i_q, i_d, j_q, j_d, k_q, k_d, n_q, n_d;
  logic [IdxW:0] kend;

  function automatic logic [AddrW-1:0] ad(logic [IdxW:0] r, logic [IdxW:0] c);
    return {r[IdxW-1:0], c[IdxW-1:0]};
  endfunction

  // inner loop bounds: k from kstart to kend
  always_comb begin
    case (ph_q)
      PhPiv:   kend = j_q;
      PhOff:   kend = j_q;
      PhFwd:   kend = i_q;
      default: kend = n_q;
    endcase
  end

  always_comb begin
    st_d = st_q; ph_d = ph_q; i_d = i_q; j_d = j_q; k_d = k_q; n_d = n_q;
    cmd_o = '0;
    out_valid_o = 1'b0; out_fail_o = 1'b0;
    out_idx_o = i_q[IdxW-1:0];
    out_last_o = (i_q == n_q - 1'b1);
    case (st_q)
      StIdle: begin
        if (start_i) begin
          n_d = n_i; j_d = '0; i_d = '0; ph_d = PhPiv; st_d = StInit;
        end
      end
      // seed accumulator
      StInit: begin
        case (ph_q)
          PhPiv: begin cmd_o.mem_addr = ad(j_q, j_q); k_d = '0; end
          PhOff: begin cmd_o.mem_addr = ad(i_q, j_q); k_d = '0; end
          PhFwd: begin
            cmd_o.acc_init = 1'b1; cmd_o.init_src = InitVec;
            cmd_o.op_idx = i_q[IdxW-1:0]; k_d = '0;
          end
          default: begin
            cmd_o.acc_init = 1'b1; cmd_o.init_src = InitY;
            cmd_o.op_idx = i_q[IdxW-1:0]; k_d = i_q + 1'b1;
          end
        endcase
        cmd_o.mem_rd = 1'b1;
        if (ph_q == PhPiv || ph_q == PhOff) cmd_o.acc_init = 1'b1;
        cmd_o.init_src = (ph_q == PhFwd) ? InitVec : (ph_q == PhBwd) ? InitY : InitMat;
        st_d = StIw;
      end
      StIw: st_d = StRdA;
      // read first factor of product
      StRdA: begin
        if (k_q >= kend) begin
          st_d = StMw;
        end else begin
          case (ph_q)
            PhPiv:   cmd_o.mem_addr = ad(j_q, k_q);
            PhOff:   cmd_o.mem_addr = ad(i_q, k_q);
            PhFwd:   cmd_o.mem_addr = ad(i_q, k_q);
            default: cmd_o.mem_addr = ad(k_q, i_q);
          endcase
          cmd_o.mem_rd = 1'b1;
          st_d = StRdB;
        end
      end
      StRdB: begin
        cmd_o.mul_a_cap = 1'b1;
        case (ph_q)
          PhPiv:   begin cmd_o.mem_addr = ad(j_q, k_q); cmd_o.op_src = OpMat; end
          PhOff:   begin cmd_o.mem_addr = ad(j_q, k_q); cmd_o.op_src = OpMat; end
          PhFwd:   begin cmd_o.op_src = OpY; end
          default: begin cmd_o.op_src = OpX; end
        endcase
        cmd_o.op_idx = k_q[IdxW-1:0];
        cmd_o.mem_rd = 1'b1;
        cmd_o.mac_go = 1'b1;
        k_d = k_q + 1'b1;
        st_d = StRdA;
      end
      // drain MAC, then load divisor
      StMw: begin
        cmd_o.mem_addr = (ph_q == PhOff) ? ad(j_q, j_q) : ad(i_q, i_q);
        cmd_o.mem_rd = 1'b1;
        if (!sts_i.mac_busy) st_d = StDw;
      end
      StDw: begin
        cmd_o.mem_addr = (ph_q == PhOff) ? ad(j_q, j_q) : ad(i_q, i_q);
        st_d = StDiag;
      end
      StDiag: begin
        cmd_o.dst_idx = i_q[IdxW-1:0];
        if (ph_q == PhPiv) begin
          if (sts_i.pivot_bad) begin
            st_d = StFail;
          end else begin
            cmd_o.sqrt_go = 1'b1; cmd_o.dst_addr = ad(j_q, j_q); st_d = StUw;
          end
        end else begin
          cmd_o.diag_cap = 1'b1;
          st_d = StOp;
        end
      end
      StOp: begin
        cmd_o.div_go = 1'b1;
        cmd_o.dst_idx = i_q[IdxW-1:0];
        cmd_o.dst_addr = ad(i_q, j_q);
        cmd_o.div_dst = (ph_q == PhOff) ? DstMat : (ph_q == PhFwd) ? DstY : DstX;
        st_d = StUw;
      end
      // wait on divider, step loops
      StUw: begin
        if (!sts_i.unit_busy && !cmd_o.div_go) begin
          st_d = StInit;
          case (ph_q)
            PhPiv: begin
              if (j_q + 1'b1 < n_q) begin i_d = j_q + 1'b1; ph_d = PhOff; end
              else begin i_d = '0; ph_d = PhFwd; end
            end
            PhOff: begin
              if (i_q + 1'b1 < n_q) i_d = i_q + 1'b1;
              else begin j_d = j_q + 1'b1; ph_d = PhPiv; end
            end
            PhFwd: begin
              if (i_q + 1'b1 < n_q) i_d = i_q + 1'b1;
              else begin i_d = n_q - 1'b1; ph_d = PhBwd; end
            end
            default: begin
              if (i_q == '0) st_d = StEmit;
              else i_d = i_q - 1'b1;
            end
          endcase
        end
      end
      StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (i_q == n_q - 1'b1) st_d = StIdle;
          else i_d = i_q + 1'b1;
        end
      end
      StFail: begin
        out_valid_o = 1'b1; out_fail_o = 1'b1; out_last_o = 1'b1;
        out_idx_o = '0;
        if (out_ready_i) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ph_q <= PhPiv;
      i_q <= '0; j_q <= '0; k_q <= '0; n_q <= '0;
    end else begin
      st_q <= st_d; ph_q <= ph_d;
      i_q <= i_d; j_q <= j_d; k_q <= k_d; n_q <= n_d;
    end
  end

  assign busy_o = (st_q != StIdle);

endmodule
